@@ rtl/fir_pkg.sv @@
// Shared constants, word types and control structs for the FIR filter.
// No dependencies; fir_filter_direct_form and fir_mac import this package.
`default_nettype none

package fir_pkg;

    // Filter dimensions
    localparam int MAX_TAPS       = 64;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 1;
    localparam int ADDR_W         = $clog2(MAX_TAPS);

    // Port field widths
    localparam int TAP_W      = 7;
    localparam int COEF_IDX_W = 6;
    localparam int VALUE_W    = 16;

    localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(31);

    // Datapath widths
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + ADDR_W + 1;

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic signed [VALUE_W-1:0]    value;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           saturated;
    } t_out_word;

    // Control that travels alongside a pair of memory reads into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

@@ rtl/fir_filter_direct_form.sv @@
// Top level of the direct-form FIR filter: request sequencer, sample and
// coefficient RAMs, MAC pipeline and output register. Depends on fir_pkg,
// fir_ram and fir_mac.
`default_nettype none

// Direct-form FIR filter, one shared multiply-accumulate. An input word either
// writes one coefficient (no result) or filters one sample (one result word).
// Samples sit in a circular buffer RAM and coefficients in a second RAM, both
// 64 entries with registered reads. After reset the block runs a clearing
// pass over every entry of both RAMs and holds o_in_stall high meanwhile;
// tap count writes are taken during that pass. A sample (tap count clamped
// to 1..64) is handled in steps: the sample is taken, one RAM read pair per
// tap goes through the single MAC, the products are multiplied and
// accumulated, and the sum is loaded into the output register. The result
// waits in the output register while i_out_stall is high; the next input
// word is taken meanwhile, and a finished sum holds in the MAC until the
// output register frees up.
// Output: sum of coef[taps-1-k] * x[n-k], rounded half up, shifted right by
// 15 and saturated to 16 bits, with saturated set when clipped.
module fir_filter_direct_form (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [fir_pkg::TAP_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire fir_pkg::t_in_word          i_in_word,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output fir_pkg::t_out_word              o_out_word
);
    import fir_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);
    localparam logic [TAP_W-1:0]  TAPS_MAX  = TAP_W'(MAX_TAPS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [ADDR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [ADDR_W-1:0]   r_coef_addr, n_coef_addr;
    logic [TAP_W-1:0]    r_cnt, n_cnt;
    logic                r_first, n_first;
    logic [TAP_W-1:0]    r_num_taps;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                w_in_acc;
    logic                w_out_free;
    logic [TAP_W-1:0]    w_taps;
    logic [ADDR_W-1:0]   w_head_inc;

    // Sample RAM ports
    logic                w_d_we;
    logic [ADDR_W-1:0]   w_d_waddr;
    logic [SAMPLE_WIDTH-1:0] w_d_wdata;
    logic [SAMPLE_WIDTH-1:0] w_d_rdata;
    // Coefficient RAM ports
    logic                w_c_we;
    logic [ADDR_W-1:0]   w_c_waddr;
    logic [COEF_WIDTH-1:0] w_c_wdata;
    logic [COEF_WIDTH-1:0] w_c_rdata;

    t_mac_ctl            w_ctl;
    logic                w_mac_done;
    logic                w_take;
    t_out_word           w_mac_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Clamp the tap count: zero runs one tap, anything above the RAM depth runs all
    always_comb begin
        if (r_num_taps == '0) begin
            w_taps = TAP_W'(1);
        end else if (r_num_taps > TAPS_MAX) begin
            w_taps = TAPS_MAX;
        end else begin
            w_taps = r_num_taps;
        end
    end

    assign w_head_inc = (r_head == LAST_ADDR) ? '0 : r_head + ADDR_W'(1);

    // RAM write ports: zero fill during the clearing pass, else the accepted word
    always_comb begin
        w_d_we    = 1'b0;
        w_d_waddr = w_head_inc;
        w_d_wdata = SAMPLE_WIDTH'(i_in_word.value);
        w_c_we    = 1'b0;
        w_c_waddr = ADDR_W'(i_in_word.coef_index);
        w_c_wdata = COEF_WIDTH'(i_in_word.value);
        if (r_state == S_CLEAR) begin
            w_d_we    = 1'b1;
            w_d_waddr = r_clr_addr;
            w_d_wdata = '0;
            w_c_we    = 1'b1;
            w_c_waddr = r_clr_addr;
            w_c_wdata = '0;
        end else if (w_in_acc) begin
            w_d_we = (i_in_word.req_type == REQ_SAMPLE);
            // Drop coefficient writes beyond the store
            w_c_we = (i_in_word.req_type == REQ_COEF)
                  && (int'(i_in_word.coef_index) < MAX_TAPS);
        end
    end

    // One read pair per tap while running
    always_comb begin
        w_ctl.valid = (r_state == S_RUN);
        w_ctl.first = r_first;
        w_ctl.last  = (r_cnt == TAP_W'(1));
    end

    assign w_take = (r_state == S_DRAIN) && w_mac_done && w_out_free;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_head      = r_head;
        n_rd_ptr    = r_rd_ptr;
        n_coef_addr = r_coef_addr;
        n_cnt       = r_cnt;
        n_first     = r_first;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && (i_in_word.req_type == REQ_SAMPLE)) begin
                    // Newest sample goes one past the old head; walk back from it
                    n_head      = w_head_inc;
                    n_rd_ptr    = w_head_inc;
                    n_coef_addr = ADDR_W'(w_taps - TAP_W'(1));
                    n_cnt       = w_taps;
                    n_first     = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                n_rd_ptr    = (r_rd_ptr == '0) ? LAST_ADDR : r_rd_ptr - ADDR_W'(1);
                n_coef_addr = r_coef_addr - ADDR_W'(1);
                n_cnt       = r_cnt - TAP_W'(1);
                n_first     = 1'b0;
                if (r_cnt == TAP_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_rd_ptr    <= '0;
            r_coef_addr <= '0;
            r_cnt       <= '0;
            r_first     <= 1'b0;
            r_num_taps  <= TAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_rd_ptr    <= n_rd_ptr;
            r_coef_addr <= n_coef_addr;
            r_cnt       <= n_cnt;
            r_first     <= n_first;
            if (i_cfg_we) begin
                r_num_taps <= i_cfg_data;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: hold while stalled, load on take
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_word <= w_mac_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    fir_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_waddr),
        .i_wdata (w_d_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_d_rdata)
    );

    fir_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_c_wdata),
        .i_raddr (r_coef_addr),
        .o_rdata (w_c_rdata)
    );

    fir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_coef   ($signed(w_c_rdata)),
        .i_sample ($signed(w_d_rdata)),
        .i_take   (w_take),
        .o_done   (w_mac_done),
        .o_result (w_mac_res)
    );

`ifndef NO_ASSERTIONS
    // A sum must never finish while its taps are still being issued
    a_no_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !w_mac_done)
        else $error("MAC finished while taps still issuing");

    // The tap counter never runs out inside the issue loop
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt != '0))
        else $error("tap counter zero while running");

    // A new result word only appears from the drain step
    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DRAIN))
        else $error("output loaded outside drain");

    // Leaving drain always hands the sum to the output register
    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) && (n_state == S_IDLE) |=> o_out_valid)
        else $error("drain left without a result word");
`endif

endmodule

`default_nettype wire

@@ rtl/fir_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/fir_mac.sv @@
// Multiply-accumulate pipeline with rounding and saturation of the final sum.
// Depends on fir_pkg for widths and the t_mac_ctl / t_out_word types.
`default_nettype none

module fir_mac (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire fir_pkg::t_mac_ctl                       i_ctl,
    input  wire logic signed [fir_pkg::COEF_WIDTH-1:0]   i_coef,
    input  wire logic signed [fir_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                                    i_take,
    output logic                                         o_done,
    output fir_pkg::t_out_word                           o_result
);
    import fir_pkg::*;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX =
        (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

    t_mac_ctl                   r_s0_ctl;   // aligned with RAM read data
    t_mac_ctl                   r_s1_ctl;   // aligned with product
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_done;

    logic signed [ACC_W-1:0]    w_prod_ext;
    logic signed [ACC_W-1:0]    w_rnd;
    logic signed [ACC_W-1:0]    w_shift;

    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
            r_s1_ctl <= '0;
            r_done   <= 1'b0;
        end else begin
            r_s0_ctl <= i_ctl;
            r_s1_ctl <= r_s0_ctl;
            if (r_s1_ctl.valid && r_s1_ctl.last) begin
                r_done <= 1'b1;
            end else if (i_take) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s0_ctl.valid) begin
            r_prod <= PROD_W'(i_coef) * PROD_W'(i_sample);
        end
        if (r_s1_ctl.valid) begin
            if (r_s1_ctl.first) begin
                r_acc <= w_prod_ext;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
    end

    // Round half up, then floor shift
    assign w_rnd   = r_acc + RND;
    assign w_shift = w_rnd >>> COEF_FRAC_BITS;

    always_comb begin
        if (w_shift > Y_MAX) begin
            o_result.filtered  = Y_MAX[SAMPLE_WIDTH-1:0];
            o_result.saturated = 1'b1;
        end else if (w_shift < Y_MIN) begin
            o_result.filtered  = Y_MIN[SAMPLE_WIDTH-1:0];
            o_result.saturated = 1'b1;
        end else begin
            o_result.filtered  = w_shift[SAMPLE_WIDTH-1:0];
            o_result.saturated = 1'b0;
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for fir_filter_direct_form: walks a directed table,
// then several tap counts of random words, checked against a predictor.
// Depends on rtl/fir_pkg.sv and rtl/fir_filter_direct_form.sv.
`timescale 1ns / 1ps

module tb;
    import fir_pkg::*;

    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 220;
    localparam int LONG_HOLD   = 400;      // receiver hold-off, in cycles
    localparam int SETTLE      = 8;        // lets a trailing coefficient write land
    localparam int TAIL        = 80;       // longest sample latency plus margin
    localparam int LIMIT       = 1000000;  // watchdog, in clock cycles

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [TAP_W-1:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_stall;
    t_out_word  out_word;

    fir_filter_direct_form DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // 10 ns clock, low for the first half period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: sample history (newest at 0), coefficients, taps.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_WIDTH-1:0] sample_hist [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   coef_mem    [MAX_TAPS];
    logic [TAP_W-1:0]               taps_cfg;

    t_out_word expected_outputs [$];

    int  mismatches    = 0;
    int  cycles        = 0;
    int  hold_requests = 0;  // bumped by the stimulus, served by the receiver
    bit  quiet         = 0;  // no idling on either side once set

    typedef struct {
        t_in_word  word;
        bit        typed;    // expected output typed into the table
        t_out_word want;
    } t_stim_row;

    t_stim_row stim_table [$];

    // Clamp the tap count the way the filter does: zero acts as one tap,
    // anything past MAX_TAPS acts as MAX_TAPS.
    function automatic int active_taps();
        if (taps_cfg == 0)
            return 1;
        if (int'(taps_cfg) > MAX_TAPS)
            return MAX_TAPS;
        return int'(taps_cfg);
    endfunction

    // Shift one sample in and compute the rounded, saturated output.
    function automatic t_out_word filter_sample(logic signed [SAMPLE_WIDTH-1:0] x);
        longint    acc;
        longint    y;
        longint    hi;
        longint    lo;
        int        n;
        t_out_word r;
        for (int i = MAX_TAPS - 1; i > 0; i--)
            sample_hist[i] = sample_hist[i-1];
        sample_hist[0] = x;
        n   = active_taps();
        acc = 0;
        for (int k = 0; k < n; k++)
            acc += longint'(coef_mem[n-1-k]) * longint'(sample_hist[k]);
        // round half up, then floor shift
        acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
        y  = acc >>> COEF_FRAC_BITS;
        hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        r.saturated = 1'b0;
        if (y > hi) begin
            y = hi;
            r.saturated = 1'b1;
        end else if (y < lo) begin
            y = lo;
            r.saturated = 1'b1;
        end
        r.filtered = y[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

    // Apply one accepted word; returns 1 when it yields an output word.
    function automatic bit apply_word(t_in_word w, output t_out_word r);
        r = '0;
        if (w.req_type == REQ_COEF) begin
            coef_mem[w.coef_index] = w.value;
            return 1'b0;
        end
        r = filter_sample(w.value);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Input side. Every task here starts and ends at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        t_out_word pred;
        int        gap;
        // drop valid for a random burst now and then
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        // hold the word until the filter takes it
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        if (apply_word(w, pred))
            expected_outputs.insert(expected_outputs.size(), typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_taps(logic [TAP_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        taps_cfg  = v;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return VALUE_W'($urandom_range(0, 511)) - 16'sd256;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly samples; some coefficient writes, usually inside the active taps.
    function automatic t_in_word random_word();
        t_in_word w;
        w.value = pick_value();
        if ($urandom_range(0, 99) < 15) begin
            w.req_type = REQ_COEF;
            if ($urandom_range(0, 9) < 7)
                w.coef_index = COEF_IDX_W'($urandom_range(0, active_taps() - 1));
            else
                w.coef_index = COEF_IDX_W'($urandom);
            // keep many coefficients small so not every output clips
            if ($urandom_range(0, 1) == 0)
                w.value = w.value >>> $urandom_range(3, 8);
        end else begin
            w.req_type   = REQ_SAMPLE;
            w.coef_index = COEF_IDX_W'($urandom);
        end
        return w;
    endfunction

    task automatic run_phase(int n, bit long_hold, bit drain_pause);
        for (int i = 0; i < n; i++) begin
            // let the receiver sit while words keep coming, so the filter backs up
            if (long_hold && i == n / 4)
                hold_requests++;
            // stop sending until the filter has delivered everything
            if (drain_pause && i == n / 2)
                wait_idle();
            send_word(random_word(), 1'b0, '0);
        end
    endtask

    function automatic void add_row(logic req, int idx,
                                    logic signed [VALUE_W-1:0] v, int typed,
                                    int f, int s);
        t_stim_row r;
        r.word.req_type    = req;
        r.word.coef_index  = COEF_IDX_W'(idx);
        r.word.value       = v;
        r.typed            = (typed != 0);
        r.want.filtered    = SAMPLE_WIDTH'(f);
        r.want.saturated   = (s != 0);
        stim_table.insert(stim_table.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall bursts, one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int served;
        int burst;
        served    = 0;
        out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (served != hold_requests) begin
                served++;
                out_stall <= 1'b1;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
            end else begin
                out_stall <= 1'b0;
                @(negedge i_clk);
            end
        end
    end

    // Check every word taken from the output against the oldest expectation.
    always @(posedge i_clk) begin : check_output
        t_out_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("output word %0d/%0b with nothing expected",
                                          out_word.filtered, out_word.saturated));
            end else begin
                want = expected_outputs.pop_front();
                if (out_word.filtered !== want.filtered)
                    report_mismatch($sformatf("filtered %0d, expected %0d",
                                              out_word.filtered, want.filtered));
                if (out_word.saturated !== want.saturated)
                    report_mismatch($sformatf("saturated %0b, expected %0b",
                                              out_word.saturated, want.saturated));
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_taps [PHASES];
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word  = '0;
        phase_taps = '{1, 0, 127, 64, 65, 2, 3, 63, 31};

        // predictor starts from the reset state
        for (int i = 0; i < MAX_TAPS; i++) begin
            sample_hist[i] = '0;
            coef_mem[i]    = '0;
        end
        taps_cfg = TAP_RESET;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset tap count (31): the newest sample meets
        // coefficient 30, the one before it coefficient 29.
        add_row(REQ_SAMPLE, 0,  16'sh7FFF, 1, 16'sd0, 0);     // zero coefficients
        add_row(REQ_SAMPLE, 63, 16'sh8000, 1, 16'sd0, 0);
        add_row(REQ_COEF,   30, 16'sh7FFF, 0, 0, 0);
        add_row(REQ_SAMPLE, 0,  16'sd1000, 0, 0, 0);
        add_row(REQ_COEF,   0,  16'sh8000, 0, 0, 0);
        add_row(REQ_COEF,   29, 16'sh8000, 0, 0, 0);
        add_row(REQ_SAMPLE, 0,  16'sh7FFF, 0, 0, 0);
        add_row(REQ_SAMPLE, 0,  16'sh8000, 1, 16'sh8000, 1);  // clips low
        add_row(REQ_SAMPLE, 0,  16'sh7FFF, 1, 16'sh7FFF, 1);  // clips high
        add_row(REQ_COEF,   63, 16'sh1234, 0, 0, 0);          // outside the active taps
        add_row(REQ_COEF,   30, 16'sd1,    0, 0, 0);
        add_row(REQ_COEF,   29, 16'sd0,    0, 0, 0);
        add_row(REQ_SAMPLE, 0,  16'sd16384,  1, 16'sd1, 0);   // half rounds up
        add_row(REQ_SAMPLE, 0, -16'sd16384,  1, 16'sd0, 0);   // minus half rounds up too
        add_row(REQ_SAMPLE, 0, -16'sd16385,  1, -16'sd1, 0);
        add_row(REQ_COEF,   30, 16'sh8000, 0, 0, 0);          // coefficient of -1.0
        add_row(REQ_SAMPLE, 0,  16'sh8000, 1, 16'sh7FFF, 1);  // -1.0 * -1.0 clips
        add_row(REQ_SAMPLE, 0,  16'sd0,    1, 16'sd0, 0);
        add_row(REQ_COEF,   15, 16'sh5555, 0, 0, 0);
        add_row(REQ_COEF,   42, 16'shAAAA, 0, 0, 0);
        add_row(REQ_SAMPLE, 21, 16'sh2AAA, 0, 0, 0);
        add_row(REQ_SAMPLE, 42, 16'sh5555, 0, 0, 0);
        add_row(REQ_SAMPLE, 0,  -16'sd1,   0, 0, 0);

        foreach (stim_table[i])
            send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);

        // Random phases, each at its own tap count; extremes and the clamped
        // values (zero, past MAX_TAPS) included.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_taps(TAP_W'(phase_taps[p]));
            if (p == PHASES - 1)
                quiet = 1;
            run_phase(PHASE_WORDS, p == 3, p == 5);
        end

        // Drain, then give the filter time to show any stray word.
        wait_idle();
        repeat (TAIL) @(negedge i_clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
